FILE: design/tpba_pkg.sv
// Shared types, codes and constants of the top-view pixel binning accumulator.
package tpba_pkg;

   localparam int MAX_SIDE_DEF = 256;
   localparam int QUEUE_DEPTH  = 2;

   localparam logic [47:0] ACC_MAX = 48'hFFFF_FFFF_FFFF;
   localparam logic [47:0] FX_ONE  = 48'h0000_0001_0000;
   localparam logic [47:0] FX_HALF = 48'h0000_0000_8000;

   localparam logic [1:0]  MODE_RESET = 2'd0;
   localparam logic [31:0] PPU_RESET  = 32'h0080_0000;
   localparam logic [8:0]  SIDE_RESET = 9'd256;

   localparam logic [1:0] REQ_SAMPLE = 2'd0;
   localparam logic [1:0] REQ_MERGE  = 2'd1;
   localparam logic [1:0] REQ_READ   = 2'd2;
   localparam logic [1:0] REQ_NONE   = 2'd3;

   localparam logic [1:0] MODE_INTENSITY = 2'd0;
   localparam logic [1:0] MODE_MARK      = 2'd1;
   localparam logic [1:0] MODE_HIST      = 2'd2;

   localparam logic [1:0] STS_OK       = 2'd0;
   localparam logic [1:0] STS_OFF_GRID = 2'd1;
   localparam logic [1:0] STS_SAT      = 2'd2;

   localparam logic [1:0] CSR_MODE = 2'd0;
   localparam logic [1:0] CSR_PPU  = 2'd1;
   localparam logic [1:0] CSR_SIDE = 2'd2;

   typedef enum logic [2:0] {
      OP_REPLY,
      OP_RUN_ADD,
      OP_RUN_MARK,
      OP_RES_HIT,
      OP_READ,
      OP_MERGE_ADD,
      OP_MERGE_MARK
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [1:0]  status;
      logic [47:0] value;
   } cmd_type;

   typedef enum logic [2:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_ACCESS,
      BK_MERGE,
      BK_FLUSH,
      BK_REPLY
   } bk_state_type;

endpackage

FILE: design/tpba_front.sv
// Front end: configuration registers, word intake, scaling products and command classification.
module tpba_front #(
   parameter int MAX_SIDE = tpba_pkg::MAX_SIDE_DEF,
   localparam int IW = $clog2(MAX_SIDE),
   localparam int AW = 2 * IW
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [1:0]           csr_index,
   input  logic [31:0]          csr_wdata,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_type,
   input  logic signed [31:0]   req_pos_x,
   input  logic signed [31:0]   req_pos_y,
   input  logic [31:0]          req_brightness,
   input  logic [31:0]          req_differential,
   input  logic [7:0]           req_read_row,
   input  logic [7:0]           req_read_col,
   input  logic                 clear_busy,
   input  logic                 cmd_full,
   output logic                 cmd_push,
   output tpba_pkg::cmd_type    cmd_out,
   output logic [AW-1:0]        cmd_addr
);
   import tpba_pkg::*;

   localparam int SW = $clog2(MAX_SIDE + 1);
   localparam int CW = (SW > 9) ? SW : 9;
   localparam int RW = (IW > 8) ? IW : 8;

   logic [1:0]  mode_ff;
   logic [31:0] ppu_ff;
   logic [8:0]  side_ff;

   logic        s1_valid_ff, s1_valid_in;
   logic [1:0]  s1_kind_ff;
   logic        s1_neg_x_ff, s1_neg_y_ff;
   logic [63:0] s1_prod_x_ff, s1_prod_y_ff, s1_prod_v_ff;
   logic [7:0]  s1_row_ff, s1_col_ff;

   logic        accept;
   logic [31:0] mag_x, mag_y;
   logic [CW-1:0] side_raw, side_eff;
   logic [IW:0] x_map, y_map;
   logic [RW:0] row_ext, col_ext;
   logic        read_off;

   // Maps a scaled magnitude to a grid index; the top bit flags a miss.
   function automatic logic [IW:0] map_idx(input logic neg, input logic [63:0] prod,
                                           input logic [CW-1:0] side);
      logic [32:0]   r;
      logic [CW-1:0] half;
      logic          off;
      logic [IW-1:0] idx;
      r    = 33'((65'(prod) + 65'h0_8000_0000) >> 32);
      half = side >> 1;
      if (neg) begin
         off = r > 33'(half);
         idx = IW'(half - CW'(r));
      end else begin
         off = r >= 33'(side - half);
         idx = IW'(half + CW'(r));
      end
      return {off, idx};
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_RESET;
         ppu_ff  <= PPU_RESET;
         side_ff <= SIDE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MODE: mode_ff <= csr_wdata[1:0];
            CSR_PPU:  ppu_ff  <= csr_wdata;
            CSR_SIDE: side_ff <= csr_wdata[8:0];
            default: ;
         endcase
      end
   end

   assign cmd_push  = s1_valid_ff && !cmd_full;
   assign req_stall = clear_busy || (s1_valid_ff && cmd_full);
   assign accept    = req_valid && !req_stall;

   assign mag_x = req_pos_x[31] ? $unsigned(-req_pos_x) : $unsigned(req_pos_x);
   assign mag_y = req_pos_y[31] ? $unsigned(-req_pos_y) : $unsigned(req_pos_y);

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (cmd_push) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_kind_ff   <= req_type;
         s1_neg_x_ff  <= req_pos_x[31];
         s1_neg_y_ff  <= req_pos_y[31];
         s1_prod_x_ff <= 64'(mag_x) * 64'(ppu_ff);
         s1_prod_y_ff <= 64'(mag_y) * 64'(ppu_ff);
         s1_prod_v_ff <= 64'(req_brightness) * 64'(req_differential);
         s1_row_ff    <= req_read_row;
         s1_col_ff    <= req_read_col;
      end
   end

   // A side of zero behaves as one; anything beyond the storage is clipped to it.
   always_comb begin
      side_raw = CW'(side_ff);
      if (side_ff == 9'd0) begin
         side_eff = CW'(1);
      end else if (side_raw > CW'(MAX_SIDE)) begin
         side_eff = CW'(MAX_SIDE);
      end else begin
         side_eff = side_raw;
      end
   end

   assign x_map    = map_idx(s1_neg_x_ff, s1_prod_x_ff, side_eff);
   assign y_map    = map_idx(s1_neg_y_ff, s1_prod_y_ff, side_eff);
   assign row_ext  = (RW + 1)'(s1_row_ff);
   assign col_ext  = (RW + 1)'(s1_col_ff);
   assign read_off = (row_ext >= (RW + 1)'(MAX_SIDE)) || (col_ext >= (RW + 1)'(MAX_SIDE));

   always_comb begin
      cmd_out.op     = OP_REPLY;
      cmd_out.status = STS_OK;
      cmd_out.value  = 48'((65'(s1_prod_v_ff) + 65'h8000) >> 16);
      cmd_addr       = {y_map[IW-1:0], x_map[IW-1:0]};
      case (s1_kind_ff)
         REQ_SAMPLE: begin
            if (x_map[IW] || y_map[IW]) begin
               cmd_out.status = STS_OFF_GRID;
            end else begin
               case (mode_ff)
                  MODE_INTENSITY: cmd_out.op = OP_RUN_ADD;
                  MODE_HIST:      cmd_out.op = OP_RES_HIT;
                  MODE_MARK:      cmd_out.op = OP_RUN_MARK;
                  default:        cmd_out.op = OP_RUN_MARK;
               endcase
            end
         end
         REQ_MERGE: begin
            if (mode_ff inside {MODE_INTENSITY, MODE_HIST}) begin
               cmd_out.op = OP_MERGE_ADD;
            end else begin
               cmd_out.op = OP_MERGE_MARK;
            end
         end
         REQ_READ: begin
            cmd_addr = {row_ext[IW-1:0], col_ext[IW-1:0]};
            if (read_off) begin
               cmd_out.status = STS_OFF_GRID;
            end else begin
               cmd_out.op = OP_READ;
            end
         end
         REQ_NONE: cmd_out.op = OP_REPLY;
         default:  cmd_out.op = OP_REPLY;
      endcase
   end

endmodule

FILE: design/tpba_queue.sv
// Short command queue between the front end and the image back end.
module tpba_queue #(
   parameter int AW = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  tpba_pkg::cmd_type push_cmd,
   input  logic [AW-1:0]     push_addr,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output tpba_pkg::cmd_type head_cmd,
   output logic [AW-1:0]     head_addr
);
   import tpba_pkg::*;

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int NW = $clog2(QUEUE_DEPTH + 1);

   cmd_type       q_cmd_ff  [QUEUE_DEPTH];
   logic [AW-1:0] q_addr_ff [QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0] count_ff, count_in;

   assign full       = count_ff == NW'(QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_cmd   = q_cmd_ff[rd_ptr_ff];
   assign head_addr  = q_addr_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + NW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_cmd_ff[wr_ptr_ff]  <= push_cmd;
         q_addr_ff[wr_ptr_ff] <= push_addr;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("command pushed into a full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("command popped from an empty queue");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= NW'(QUEUE_DEPTH))
      else $error("queue count beyond its depth");
`endif

endmodule

FILE: design/tpba_back.sv
// Back end: run and result image memories, command execution, merge sweep and result register.
module tpba_back #(
   parameter int MAX_SIDE = tpba_pkg::MAX_SIDE_DEF,
   localparam int IW = $clog2(MAX_SIDE),
   localparam int AW = 2 * IW
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  tpba_pkg::cmd_type q_cmd,
   input  logic [AW-1:0]     q_addr,
   output logic              q_pop,
   output logic              clear_busy,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [1:0]        rsp_status,
   output logic [47:0]       rsp_pixel_value
);
   import tpba_pkg::*;

   localparam int DEPTH = 1 << AW;

   logic [47:0] run_mem [DEPTH];
   logic [47:0] res_mem [DEPTH];

   bk_state_type  st_ff, st_in;
   logic [AW-1:0] cnt_ff, cnt_in;
   logic          pend_ff, pend_in;
   logic [AW-1:0] pend_addr_ff, pend_addr_in;
   logic          sat_ff, sat_in;
   cmd_type       cur_cmd_ff, cur_cmd_in;
   logic [AW-1:0] cur_addr_ff, cur_addr_in;
   logic [47:0]   run_q_ff, res_q_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    rsp_status_ff;
   logic [47:0]   rsp_pixel_ff;

   logic          out_free;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic          run_we, res_we;
   logic [AW-1:0] run_waddr, res_waddr;
   logic [47:0]   run_wdata, res_wdata;
   logic          load_rsp;
   logic [1:0]    load_status;
   logic [47:0]   load_pixel;
   logic [48:0]   run_sum, res_sum, merge_sum;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign clear_busy = st_ff == BK_CLEAR;

   assign run_sum   = 49'(run_q_ff) + 49'(cur_cmd_ff.value);
   assign res_sum   = 49'(res_q_ff) + 49'(FX_ONE);
   assign merge_sum = 49'(res_q_ff) + 49'(run_q_ff);

   always_comb begin
      st_in = st_ff;
      case (st_ff)
         BK_CLEAR: begin
            if (&cnt_ff) begin
               st_in = BK_IDLE;
            end
         end
         BK_IDLE: begin
            if (q_valid && q_cmd.op != OP_REPLY) begin
               if (q_cmd.op inside {OP_MERGE_ADD, OP_MERGE_MARK}) begin
                  st_in = BK_MERGE;
               end else begin
                  st_in = BK_ACCESS;
               end
            end
         end
         BK_ACCESS: begin
            if (out_free) begin
               st_in = BK_IDLE;
            end
         end
         BK_MERGE: begin
            if (&cnt_ff) begin
               st_in = BK_FLUSH;
            end
         end
         BK_FLUSH: st_in = BK_REPLY;
         BK_REPLY: begin
            if (out_free) begin
               st_in = BK_IDLE;
            end
         end
         default: st_in = BK_IDLE;
      endcase
   end

   always_comb begin
      q_pop        = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = cnt_ff;
      run_we       = 1'b0;
      run_waddr    = cnt_ff;
      run_wdata    = '0;
      res_we       = 1'b0;
      res_waddr    = cnt_ff;
      res_wdata    = '0;
      load_rsp     = 1'b0;
      load_status  = STS_OK;
      load_pixel   = '0;
      cnt_in       = cnt_ff;
      pend_in      = 1'b0;
      pend_addr_in = cnt_ff;
      sat_in       = sat_ff;
      cur_cmd_in   = cur_cmd_ff;
      cur_addr_in  = cur_addr_ff;
      case (st_ff)
         BK_CLEAR: begin
            run_we = 1'b1;
            res_we = 1'b1;
            cnt_in = cnt_ff + AW'(1);
         end
         BK_IDLE: begin
            if (q_valid) begin
               if (q_cmd.op == OP_REPLY) begin
                  if (out_free) begin
                     q_pop       = 1'b1;
                     load_rsp    = 1'b1;
                     load_status = q_cmd.status;
                  end
               end else begin
                  q_pop       = 1'b1;
                  cur_cmd_in  = q_cmd;
                  cur_addr_in = q_addr;
                  sat_in      = 1'b0;
                  rd_en       = !(q_cmd.op inside {OP_MERGE_ADD, OP_MERGE_MARK});
                  rd_addr     = q_addr;
               end
            end
         end
         BK_ACCESS: begin
            run_waddr = cur_addr_ff;
            res_waddr = cur_addr_ff;
            if (out_free) begin
               load_rsp = 1'b1;
               case (cur_cmd_ff.op)
                  OP_RUN_ADD: begin
                     run_we = 1'b1;
                     if (run_sum > 49'(ACC_MAX)) begin
                        run_wdata   = ACC_MAX;
                        load_status = STS_SAT;
                     end else begin
                        run_wdata = run_sum[47:0];
                     end
                  end
                  OP_RUN_MARK: begin
                     run_we    = 1'b1;
                     run_wdata = FX_ONE;
                  end
                  OP_RES_HIT: begin
                     res_we = 1'b1;
                     if (res_sum > 49'(ACC_MAX)) begin
                        res_wdata   = ACC_MAX;
                        load_status = STS_SAT;
                     end else begin
                        res_wdata = res_sum[47:0];
                     end
                  end
                  OP_READ: load_pixel = res_q_ff;
                  default: ;
               endcase
            end
         end
         BK_MERGE: begin
            rd_en   = 1'b1;
            cnt_in  = cnt_ff + AW'(1);
            pend_in = 1'b1;
         end
         BK_FLUSH: ;
         BK_REPLY: begin
            if (out_free) begin
               load_rsp    = 1'b1;
               load_status = sat_ff ? STS_SAT : STS_OK;
            end
         end
         default: ;
      endcase

      // Write-back half of the merge sweep, one entry behind the read.
      if (pend_ff) begin
         run_we    = 1'b1;
         run_waddr = pend_addr_ff;
         run_wdata = '0;
         res_we    = 1'b1;
         res_waddr = pend_addr_ff;
         if (cur_cmd_ff.op == OP_MERGE_ADD) begin
            if (merge_sum > 49'(ACC_MAX)) begin
               res_wdata = ACC_MAX;
               sat_in    = 1'b1;
            end else begin
               res_wdata = merge_sum[47:0];
            end
         end else begin
            res_wdata = (run_q_ff > FX_HALF) ? FX_ONE : res_q_ff;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= BK_CLEAR;
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         sat_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
         sat_ff       <= sat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_addr_ff <= pend_addr_in;
      cur_cmd_ff   <= cur_cmd_in;
      cur_addr_ff  <= cur_addr_in;
      if (load_rsp) begin
         rsp_status_ff <= load_status;
         rsp_pixel_ff  <= load_pixel;
      end
   end

   always_ff @(posedge clock) begin
      if (run_we) begin
         run_mem[run_waddr] <= run_wdata;
      end
      if (rd_en) begin
         run_q_ff <= run_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (res_we) begin
         res_mem[res_waddr] <= res_wdata;
      end
      if (rd_en) begin
         res_q_ff <= res_mem[rd_addr];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_pixel_value = rsp_pixel_ff;

`ifndef NO_ASSERTIONS
   a_no_pop_in_clear: assert property (@(posedge clock) disable iff (reset)
      (st_ff == BK_CLEAR) |-> !q_pop)
      else $error("command taken during the clearing pass");
   a_access_done: assert property (@(posedge clock) disable iff (reset)
      (st_ff == BK_ACCESS && out_free) |=> (st_ff == BK_IDLE))
      else $error("pixel access did not complete");
   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      (st_ff == BK_IDLE) |-> (cnt_ff == '0 && !pend_ff))
      else $error("sweep state left over in idle");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load_rsp |-> out_free)
      else $error("result register overwritten before it was taken");
`endif

endmodule

FILE: design/topview_pixel_binning_accumulator.sv
// A sample or read passes the front-end register, the command queue, the memory read and
// the result register; a word needing no memory access (off grid, off storage, type three)
// skips the read. The back end takes one command at a time (memory read, then write-back);
// an end-of-run merge sweeps all MAX_SIDE*MAX_SIDE entries at one per cycle, then flushes.
// Reset: synchronous; a clearing pass of all MAX_SIDE*MAX_SIDE entries (65536 by default)
// zeroes both images, during which req_stall stays high; configuration writes still land.
module topview_pixel_binning_accumulator #(
   parameter int MAX_SIDE = tpba_pkg::MAX_SIDE_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [1:0]          csr_index,
   input  logic [31:0]         csr_wdata,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_type,
   input  logic signed [31:0]  req_pos_x,
   input  logic signed [31:0]  req_pos_y,
   input  logic [31:0]         req_brightness,
   input  logic [31:0]         req_differential,
   input  logic [7:0]          req_read_row,
   input  logic [7:0]          req_read_col,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_status,
   output logic [47:0]         rsp_pixel_value
);
   import tpba_pkg::*;

   localparam int AW = 2 * $clog2(MAX_SIDE);

   logic          clear_busy;
   logic          cmd_full;
   logic          cmd_push;
   cmd_type       cmd_out;
   logic [AW-1:0] cmd_addr;
   logic          q_valid;
   logic          q_pop;
   cmd_type       q_cmd;
   logic [AW-1:0] q_addr;

   tpba_front #(.MAX_SIDE(MAX_SIDE)) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_brightness   (req_brightness),
      .req_differential (req_differential),
      .req_read_row     (req_read_row),
      .req_read_col     (req_read_col),
      .clear_busy       (clear_busy),
      .cmd_full         (cmd_full),
      .cmd_push         (cmd_push),
      .cmd_out          (cmd_out),
      .cmd_addr         (cmd_addr)
   );

   tpba_queue #(.AW(AW)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (cmd_push),
      .push_cmd   (cmd_out),
      .push_addr  (cmd_addr),
      .full       (cmd_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_cmd   (q_cmd),
      .head_addr  (q_addr)
   );

   tpba_back #(.MAX_SIDE(MAX_SIDE)) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_cmd           (q_cmd),
      .q_addr          (q_addr),
      .q_pop           (q_pop),
      .clear_busy      (clear_busy),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_pixel_value (rsp_pixel_value)
   );

endmodule

FILE: tb/tb_topview_pixel_binning_accumulator.sv
// Self-checking testbench of the top-view pixel binning accumulator.
module tb_topview_pixel_binning_accumulator;
   import tpba_pkg::*;

   localparam int SIDE        = MAX_SIDE_DEF;
   localparam int PIX_COUNT   = SIDE * SIDE;
   localparam int QUIET_LIMIT = 200000;
   localparam int PLAN_ROWS   = 35;

   // Mode three has no name in the package; it behaves as the mark mode.
   localparam logic [1:0] MODE_MARK_ALIAS = 2'd3;

   typedef enum logic {ROW_WORD, ROW_CSR} plan_kind_type;

   typedef struct packed {
      logic [1:0]  req;
      logic [31:0] pos_x;
      logic [31:0] pos_y;
      logic [31:0] bright;
      logic [31:0] diff;
      logic [7:0]  row;
      logic [7:0]  col;
   } bin_word_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [47:0] value;
   } pixel_result_type;

   typedef struct packed {
      plan_kind_type    kind;
      logic [1:0]       csr_idx;
      logic [31:0]      csr_data;
      bin_word_type     word;
      logic             has_literal;
      pixel_result_type literal;
   } plan_row_type;

   logic               clock;
   logic               reset;
   logic               csr_we;
   logic [1:0]         csr_index;
   logic [31:0]        csr_wdata;
   logic               req_valid;
   logic               req_stall;
   logic [1:0]         req_type;
   logic signed [31:0] req_pos_x;
   logic signed [31:0] req_pos_y;
   logic [31:0]        req_brightness;
   logic [31:0]        req_differential;
   logic [7:0]         req_read_row;
   logic [7:0]         req_read_col;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [1:0]         rsp_status;
   logic [47:0]        rsp_pixel_value;

   logic [47:0]      run_img [0:PIX_COUNT-1];
   logic [47:0]      res_img [0:PIX_COUNT-1];
   logic [1:0]       mode_q;
   logic [31:0]      ppu_q;
   logic [8:0]       side_q;
   pixel_result_type pending_pixel_results [$];
   pixel_result_type oldest;
   plan_row_type     directed_plan [0:PLAN_ROWS-1];
   int               mismatch_count;
   int               quiet_cycles;
   int               send_gap_pct;
   int               rsp_stall_pct;

   topview_pixel_binning_accumulator DUT (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_brightness   (req_brightness),
      .req_differential (req_differential),
      .req_read_row     (req_read_row),
      .req_read_col     (req_read_col),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_pixel_value  (rsp_pixel_value)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int unsigned active_side();
      if (side_q == 0) return 1;
      if (side_q > SIDE) return SIDE;
      return side_q;
   endfunction

   // Rounds position times scale half away from zero and centers it on the grid.
   function automatic bit grid_index(input logic [31:0] raw, input int unsigned side,
                                     output int unsigned idx);
      logic [63:0] mag;
      logic [63:0] r;
      int unsigned half;
      mag  = raw[31] ? (64'h1_0000_0000 - {32'b0, raw}) : {32'b0, raw};
      r    = (mag * {32'b0, ppu_q} + 64'h8000_0000) >> 32;
      half = side / 2;
      idx  = 0;
      if (raw[31]) begin
         if (r > half) return 1'b0;
         idx = half - r[31:0];
      end else begin
         if (r >= side - half) return 1'b0;
         idx = half + r[31:0];
      end
      return 1'b1;
   endfunction

   function automatic logic [47:0] clamp_add(input logic [47:0] acc, input logic [47:0] inc,
                                             output logic ovf);
      logic [48:0] sum;
      sum = {1'b0, acc} + {1'b0, inc};
      ovf = sum[48];
      return sum[48] ? ACC_MAX : sum[47:0];
   endfunction

   // Applies one word to the image copies and returns the result word it causes.
   function automatic pixel_result_type bin_outcome(input bin_word_type w);
      pixel_result_type res;
      int unsigned      col;
      int unsigned      row;
      int unsigned      addr;
      int unsigned      side;
      logic [63:0]      prod;
      logic             ovf;
      logic             additive;
      res  = '0;
      side = active_side();
      case (w.req)
         REQ_SAMPLE: begin
            if (!grid_index(w.pos_x, side, col) || !grid_index(w.pos_y, side, row)) begin
               res.status = STS_OFF_GRID;
            end else begin
               addr = row * SIDE + col;
               if (mode_q == MODE_INTENSITY) begin
                  prod = 64'(w.bright) * 64'(w.diff);
                  run_img[addr] = clamp_add(run_img[addr], 48'((prod + 64'h8000) >> 16), ovf);
                  if (ovf) res.status = STS_SAT;
               end else if (mode_q == MODE_HIST) begin
                  res_img[addr] = clamp_add(res_img[addr], FX_ONE, ovf);
                  if (ovf) res.status = STS_SAT;
               end else begin
                  run_img[addr] = FX_ONE;
               end
            end
         end
         REQ_MERGE: begin
            additive = (mode_q == MODE_INTENSITY) || (mode_q == MODE_HIST);
            for (int k = 0; k < PIX_COUNT; k++) begin
               if (additive) begin
                  res_img[k] = clamp_add(res_img[k], run_img[k], ovf);
                  if (ovf) res.status = STS_SAT;
               end else if (run_img[k] > FX_HALF) begin
                  res_img[k] = FX_ONE;
               end
               run_img[k] = '0;
            end
         end
         REQ_READ: begin
            res.value = res_img[w.row * SIDE + w.col];
         end
         default: begin
         end
      endcase
      return res;
   endfunction

   function automatic plan_row_type s_row(input logic [31:0] x, input logic [31:0] y,
                                          input logic [31:0] b, input logic [31:0] d,
                                          input logic lit, input logic [1:0] st);
      plan_row_type p;
      p = '0;
      p.kind = ROW_WORD;
      p.word.req = REQ_SAMPLE;
      p.word.pos_x = x;
      p.word.pos_y = y;
      p.word.bright = b;
      p.word.diff = d;
      p.has_literal = lit;
      p.literal.status = st;
      return p;
   endfunction

   function automatic plan_row_type r_row(input logic [1:0] t, input logic [7:0] r,
                                          input logic [7:0] c, input logic lit,
                                          input logic [47:0] val);
      plan_row_type p;
      p = '0;
      p.kind = ROW_WORD;
      p.word.req = t;
      p.word.row = r;
      p.word.col = c;
      p.has_literal = lit;
      p.literal.status = STS_OK;
      p.literal.value = val;
      return p;
   endfunction

   function automatic plan_row_type m_row(input logic lit, input logic [1:0] st);
      plan_row_type p;
      p = '0;
      p.kind = ROW_WORD;
      p.word.req = REQ_MERGE;
      p.has_literal = lit;
      p.literal.status = st;
      return p;
   endfunction

   function automatic plan_row_type c_row(input logic [1:0] idx, input logic [31:0] data);
      plan_row_type p;
      p = '0;
      p.kind = ROW_CSR;
      p.csr_idx = idx;
      p.csr_data = data;
      return p;
   endfunction

   function automatic bin_word_type merge_word();
      bin_word_type w;
      w     = '0;
      w.req = REQ_MERGE;
      return w;
   endfunction

   function automatic logic [31:0] intensity_level();
      case ($urandom_range(0, 9))
         9: return 32'hFFFF_FFFF;
         6, 7, 8: return $urandom;
         default: return $urandom_range(0, 32'h3_FFFF);
      endcase
   endfunction

   // Picks a position on or beside the grid at the current scale (random if extreme).
   function automatic logic [31:0] aimed_pos(input int unsigned side);
      int step;
      int k;
      int jit;
      if (ppu_q < 32'h4000 || ppu_q > 32'h0100_0000) return $urandom;
      step = int'(64'h1_0000_0000 / 64'(ppu_q));
      k    = int'($urandom_range(0, side + 3)) - int'(side / 2) - 2;
      jit  = int'($urandom_range(0, step / 2)) - step / 4;
      return 32'(k * step + jit);
   endfunction

   function automatic bin_word_type random_word(input bit read_only);
      bin_word_type w;
      int unsigned  pick;
      int unsigned  side;
      side     = active_side();
      w.req    = REQ_SAMPLE;
      w.pos_x  = $urandom;
      w.pos_y  = $urandom;
      w.bright = intensity_level();
      w.diff   = intensity_level();
      w.row    = 8'($urandom);
      w.col    = 8'($urandom);
      pick     = read_only ? 80 : $urandom_range(0, 99);
      if (pick < 62) begin
         w.pos_x = aimed_pos(side);
         w.pos_y = aimed_pos(side);
      end else if (pick >= 76 && pick < 96) begin
         w.req = REQ_READ;
         if ($urandom_range(0, 3) != 0) begin
            w.row = 8'($urandom_range(0, side > 254 ? 255 : side + 1));
            w.col = 8'($urandom_range(0, side > 254 ? 255 : side + 1));
         end
      end else if (pick >= 96) begin
         w.req = REQ_NONE;
      end
      return w;
   endfunction

   task automatic send_word(input bin_word_type w, input logic has_lit,
                            input pixel_result_type lit);
      pixel_result_type outcome;
      while ($urandom_range(0, 99) < send_gap_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid        <= 1'b1;
      req_type         <= w.req;
      req_pos_x        <= w.pos_x;
      req_pos_y        <= w.pos_y;
      req_brightness   <= w.bright;
      req_differential <= w.diff;
      req_read_row     <= w.row;
      req_read_col     <= w.col;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      outcome = bin_outcome(w);
      pending_pixel_results.push_back(has_lit ? lit : outcome);
   endtask

   // Drops valid and holds off until every result word has come back.
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_pixel_results.size() != 0) @(posedge clock);
   endtask

   task automatic reg_write(input logic [1:0] idx, input logic [31:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_MODE: mode_q = data[1:0];
         CSR_PPU:  ppu_q  = data;
         CSR_SIDE: side_q = data[8:0];
         default: begin
         end
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_pixel_results.size() == 0) begin
            $error("unexpected result word: status %0d, pixel_value %h",
                   rsp_status, rsp_pixel_value);
            mismatch_count++;
         end else begin
            oldest = pending_pixel_results.pop_front();
            if (rsp_status !== oldest.status) begin
               $error("status: expected %0d, actual %0d", oldest.status, rsp_status);
               mismatch_count++;
            end
            if (rsp_pixel_value !== oldest.value) begin
               $error("pixel_value: expected %h, actual %h", oldest.value, rsp_pixel_value);
               mismatch_count++;
            end
         end
      end
   end

   // The clearing pass after reset and each merge sweep are the longest quiet stretches.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      reset            = 1'b1;
      csr_we           = 1'b0;
      csr_index        = CSR_MODE;
      csr_wdata        = '0;
      req_valid        = 1'b0;
      req_type         = REQ_NONE;
      req_pos_x        = '0;
      req_pos_y        = '0;
      req_brightness   = '0;
      req_differential = '0;
      req_read_row     = '0;
      req_read_col     = '0;
      send_gap_pct     = 20;
      rsp_stall_pct    = 88;
      mode_q           = MODE_RESET;
      ppu_q            = PPU_RESET;
      side_q           = SIDE_RESET;
      for (int k = 0; k < PIX_COUNT; k++) begin
         run_img[k] = '0;
         res_img[k] = '0;
      end

      directed_plan = '{
         r_row(REQ_READ, 8'd0, 8'd0, 1'b1, 48'h0),
         r_row(REQ_READ, 8'd255, 8'd255, 1'b1, 48'h0),
         r_row(REQ_NONE, 8'd255, 8'd255, 1'b1, 48'h0),
         s_row(32'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, STS_OK),
         s_row(32'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, STS_SAT),
         s_row(32'h7FFF_FFFF, 32'h0, 32'h1, 32'h1, 1'b1, STS_OFF_GRID),
         s_row(32'h0, 32'h8000_0000, 32'h1, 32'h1, 1'b1, STS_OFF_GRID),
         m_row(1'b0, STS_OK),
         r_row(REQ_READ, 8'd128, 8'd128, 1'b1, ACC_MAX),
         s_row(32'h0, 32'h0, 32'h1_0000, 32'h1_0000, 1'b0, STS_OK),
         m_row(1'b1, STS_SAT),
         c_row(CSR_MODE, 32'(MODE_HIST)),
         c_row(CSR_SIDE, 32'd0),
         c_row(CSR_PPU, 32'h0),
         s_row(32'h1234_5678, 32'hDEAD_BEEF, 32'h0, 32'h0, 1'b0, STS_OK),
         s_row(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0, 1'b0, STS_OK),
         r_row(REQ_READ, 8'd0, 8'd0, 1'b0, 48'h0),
         c_row(CSR_MODE, 32'(MODE_MARK)),
         c_row(CSR_SIDE, 32'd511),
         c_row(CSR_PPU, 32'hFFFF_FFFF),
         s_row(32'h0, 32'h0, 32'h0, 32'h0, 1'b0, STS_OK),
         s_row(32'h1, 32'h0, 32'h0, 32'h0, 1'b0, STS_OK),
         s_row(32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 1'b0, STS_OK),
         s_row(32'h0001_0000, 32'h0, 32'h0, 32'h0, 1'b1, STS_OFF_GRID),
         c_row(CSR_MODE, 32'(MODE_MARK_ALIAS)),
         s_row(32'h0, 32'h1, 32'h0, 32'h0, 1'b0, STS_OK),
         m_row(1'b0, STS_OK),
         r_row(REQ_READ, 8'd128, 8'd128, 1'b0, 48'h0),
         r_row(REQ_READ, 8'd128, 8'd129, 1'b0, 48'h0),
         c_row(CSR_PPU, 32'h0001_0000),
         c_row(CSR_SIDE, 32'd8),
         c_row(CSR_MODE, 32'(MODE_INTENSITY)),
         s_row(32'h0000_8000, 32'hFFFF_8000, 32'h1_8000, 32'h1_0000, 1'b0, STS_OK),
         s_row(32'h0003_8000, 32'h0, 32'h1, 32'h1, 1'b1, STS_OFF_GRID),
         s_row(32'hFFFC_8000, 32'h0, 32'h2_0000, 32'h3, 1'b0, STS_OK)
      };

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_plan[i]) begin
         if (directed_plan[i].kind == ROW_CSR) begin
            wait_drained();
            reg_write(directed_plan[i].csr_idx, directed_plan[i].csr_data);
         end else begin
            send_word(directed_plan[i].word, directed_plan[i].has_literal,
                      directed_plan[i].literal);
         end
      end

      // Each segment is a run of samples, reads and no-ops closed by a merge and six reads.
      for (int phase = 0; phase < 3; phase++) begin
         send_gap_pct  = (phase == 0) ? 20 : (phase == 1) ? 88 : 0;
         rsp_stall_pct = (phase == 0) ? 88 : (phase == 1) ? 20 : 0;
         for (int seg = 0; seg < 2; seg++) begin
            wait_drained();
            reg_write(CSR_MODE, $urandom_range(0, 3));
            case ($urandom_range(0, 5))
               0: reg_write(CSR_SIDE, 32'd1);
               1: reg_write(CSR_SIDE, 32'd256);
               2: reg_write(CSR_SIDE, $urandom_range(257, 511));
               default: reg_write(CSR_SIDE, $urandom_range(2, 20));
            endcase
            case ($urandom_range(0, 5))
               2: reg_write(CSR_PPU, 32'h0000_8000);
               3: reg_write(CSR_PPU, 32'h0002_0000);
               4: reg_write(CSR_PPU, $urandom_range(32'h4000, 32'h10_0000));
               5: reg_write(CSR_PPU, 32'hFFFF_FFFF);
               default: reg_write(CSR_PPU, 32'h0001_0000);
            endcase
            repeat (108) begin
               if ($urandom_range(0, 49) == 0) wait_drained();
               send_word(random_word(1'b0), 1'b0, '0);
            end
            send_word(merge_word(), 1'b0, '0);
            repeat (6) send_word(random_word(1'b1), 1'b0, '0);
         end
      end

      wait_drained();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
